/* sv/fixed_point_alu_defines.svh */
// Assertion macros shared by the fixed-point ALU RTL
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// ante holds in a cycle, cons holds in the same cycle
`define FPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle, cons holds after the ##dly delay
`define FPA_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

/* sv/fpa_pkg.sv */
// Package: opcodes, widths and inter-stage structs of the fixed-point ALU
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int DIV_QBITS  = 33;
    localparam int DIV_STAGES = DIV_QBITS;
    localparam int REM_W      = 64;
    localparam int TRIAL_W    = REM_W + 2;
    localparam int LAT_CYCLES = DIV_STAGES + 2;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_CMP      = 4'd6,
        OP_INC      = 4'd7,
        OP_DEC      = 4'd8,
        OP_TO_INT   = 4'd9,
        OP_FROM_INT = 4'd10
    } t_op;

    typedef struct packed {
        logic               valid;
        t_op                op;
        logic signed [31:0] res;
        logic               ovf;
        logic               dz;
        logic               neg;
        logic               lt;
        logic               eq;
        logic               gt;
    } t_side;

    typedef struct packed {
        logic [31:0] mag_a;
        logic [31:0] mag_b;
    } t_mul_in;

    typedef struct packed {
        logic [REM_W-1:0]   num;
        logic [DIV_QBITS-1:0] den;
    } t_div_in;

    typedef struct packed {
        logic                 hi;
        logic [DIV_QBITS-1:0] quo;
    } t_div_out;

endpackage
`default_nettype wire

/* sv/fpa_front.sv */
// Front stage: decode, simple ops with saturation, compare flags, mul/div operand prep
`timescale 1ns / 1ps
`default_nettype none
module fpa_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [3:0]         i_op,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output fpa_pkg::t_side          o_side,
    output fpa_pkg::t_mul_in        o_mul,
    output fpa_pkg::t_div_in        o_div
);

    fpa_pkg::t_side     r_side, n_side;
    fpa_pkg::t_mul_in   r_mul, n_mul;
    fpa_pkg::t_div_in   r_div, n_div;

    logic signed [32:0] sum, diff, incv, decv;
    logic signed [63:0] fint;
    logic [31:0]        mag_a, mag_b;

    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        logic [32:0] rv;
        if (v[32] != v[31]) begin
            rv = {1'b1, (v[32] ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX)};
        end else begin
            rv = {1'b0, v[31:0]};
        end
        return rv;
    endfunction

    always_comb begin
        sum   = 33'(i_a) + 33'(i_b);
        diff  = 33'(i_a) - 33'(i_b);
        incv  = 33'(i_a) + 33'sd1;
        decv  = 33'(i_a) - 33'sd1;
        fint  = 64'(i_a) <<< fpa_pkg::FRAC_BITS;
        mag_a = i_a[31] ? 32'(-i_a) : i_a;
        mag_b = i_b[31] ? 32'(-i_b) : i_b;

        n_side       = '0;
        n_side.valid = i_valid;
        n_side.op    = fpa_pkg::t_op'(i_op);
        n_side.lt    = i_a < i_b;
        n_side.eq    = i_a == i_b;
        n_side.gt    = i_a > i_b;
        n_side.neg   = i_a[31] ^ i_b[31];

        case (fpa_pkg::t_op'(i_op))
            fpa_pkg::OP_ADD: {n_side.ovf, n_side.res} = sat33(sum);
            fpa_pkg::OP_SUB: {n_side.ovf, n_side.res} = sat33(diff);
            fpa_pkg::OP_INC: {n_side.ovf, n_side.res} = sat33(incv);
            fpa_pkg::OP_DEC: {n_side.ovf, n_side.res} = sat33(decv);
            fpa_pkg::OP_MIN: n_side.res = (i_a < i_b) ? i_a : i_b;
            fpa_pkg::OP_MAX: n_side.res = (i_a > i_b) ? i_a : i_b;
            fpa_pkg::OP_TO_INT: n_side.res = i_a >>> fpa_pkg::FRAC_BITS;
            fpa_pkg::OP_FROM_INT: begin
                if (fint > 64'(fpa_pkg::S32_MAX)) begin
                    n_side.ovf = 1'b1;
                    n_side.res = fpa_pkg::S32_MAX;
                end else if (fint < 64'(fpa_pkg::S32_MIN)) begin
                    n_side.ovf = 1'b1;
                    n_side.res = fpa_pkg::S32_MIN;
                end else begin
                    n_side.res = fint[31:0];
                end
            end
            fpa_pkg::OP_DIV: begin
                if (i_b == '0) begin
                    n_side.dz  = 1'b1;
                    n_side.res = i_a[31] ? fpa_pkg::S32_MIN :
                                 ((i_a == '0) ? 32'sd0 : fpa_pkg::S32_MAX);
                end
            end
            default: n_side.res = '0;
        endcase

        n_mul.mag_a = mag_a;
        n_mul.mag_b = mag_b;
        // rounded quotient = floor((2n + d) / (2d)), n = |a| << FRAC_BITS
        n_div.num = (fpa_pkg::REM_W'(mag_a) << (fpa_pkg::FRAC_BITS + 1))
                  + fpa_pkg::REM_W'(mag_b);
        n_div.den = {mag_b, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else begin
            r_side.valid <= n_side.valid;
        end
        r_side.op  <= n_side.op;
        r_side.res <= n_side.res;
        r_side.ovf <= n_side.ovf;
        r_side.dz  <= n_side.dz;
        r_side.neg <= n_side.neg;
        r_side.lt  <= n_side.lt;
        r_side.eq  <= n_side.eq;
        r_side.gt  <= n_side.gt;
        r_mul      <= n_mul;
        r_div      <= n_div;
    end

    assign o_side = r_side;
    assign o_mul  = r_mul;
    assign o_div  = r_div;

endmodule
`default_nettype wire

/* sv/fpa_mul.sv */
// Magnitude multiplier: one product stage, then a delay line matching the divider
`timescale 1ns / 1ps
`default_nettype none
module fpa_mul (
    input  wire logic             i_clk,
    input  wire fpa_pkg::t_mul_in i_mul,
    output logic [63:0]           o_prod
);

    logic [63:0] r_prod [fpa_pkg::DIV_STAGES];

    always_ff @(posedge i_clk) begin
        r_prod[0] <= 64'(i_mul.mag_a) * 64'(i_mul.mag_b);
        for (int k = 1; k < fpa_pkg::DIV_STAGES; k++) begin
            r_prod[k] <= r_prod[k-1];
        end
    end

    assign o_prod = r_prod[fpa_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

/* sv/fpa_div.sv */
// Restoring divider, one quotient bit per pipeline stage, with high-quotient detect
`timescale 1ns / 1ps
`default_nettype none
module fpa_div (
    input  wire logic             i_clk,
    input  wire fpa_pkg::t_div_in i_div,
    output fpa_pkg::t_div_out     o_div
);

    localparam int NS = fpa_pkg::DIV_STAGES;
    localparam int QB = fpa_pkg::DIV_QBITS;
    localparam int TW = fpa_pkg::TRIAL_W;
    localparam int RW = fpa_pkg::REM_W;

    logic [RW-1:0] r_rem [NS];
    logic [QB-1:0] r_den [NS];
    logic [QB-1:0] r_quo [NS];
    logic          r_hi  [NS];

    logic [RW-1:0] n_rem [NS];
    logic [QB-1:0] n_quo [NS];
    logic          n_hi;

    logic [RW-1:0] rem_in [NS];
    logic [QB-1:0] den_in [NS];
    logic [QB-1:0] quo_in [NS];
    logic [TW-1:0] trial  [NS];

    always_comb begin
        n_hi = {2'b00, i_div.num} >= (TW'(i_div.den) << QB);
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                rem_in[k] = i_div.num;
                den_in[k] = i_div.den;
                quo_in[k] = '0;
            end else begin
                rem_in[k] = r_rem[k-1];
                den_in[k] = r_den[k-1];
                quo_in[k] = r_quo[k-1];
            end
            trial[k] = {2'b00, rem_in[k]} - (TW'(den_in[k]) << (QB - 1 - k));
            if (!trial[k][TW-1]) begin
                n_rem[k] = trial[k][RW-1:0];
                n_quo[k] = quo_in[k] | (QB'(1) << (QB - 1 - k));
            end else begin
                n_rem[k] = rem_in[k];
                n_quo[k] = quo_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            r_rem[k] <= n_rem[k];
            r_quo[k] <= n_quo[k];
            r_den[k] <= den_in[k];
            r_hi[k]  <= (k == 0) ? n_hi : r_hi[(k == 0) ? 0 : k-1];
        end
    end

    assign o_div.hi  = r_hi[NS-1];
    assign o_div.quo = r_quo[NS-1];

endmodule
`default_nettype wire

/* sv/fixed_point_alu.sv */
// Top level: Q(32-FRAC_BITS).FRAC_BITS fixed-point ALU, fully pipelined
// Every opcode takes the same path: front register, side-band delay line, output register.
// Throughput: one word per cycle; busy is never asserted.
// The 33-stage divider (one quotient bit per stage) sets the latency.
// Reset: synchronous, active low; clears all valid bits, no result strobes after it.
// The receiver cannot stall; each result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_alu_defines.svh"
module fixed_point_alu (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [3:0]         i_op,
    input  wire logic signed [31:0] i_operand_a,
    input  wire logic signed [31:0] i_operand_b,
    output logic                    o_valid,
    output logic signed [31:0]      o_result_value,
    output logic                    o_less_than,
    output logic                    o_equal,
    output logic                    o_greater_than,
    output logic                    o_overflowed,
    output logic                    o_divided_by_zero
);

    fpa_pkg::t_side    front_side;
    fpa_pkg::t_mul_in  mul_in;
    fpa_pkg::t_div_in  div_in;
    fpa_pkg::t_div_out div_out;
    logic [63:0]       prod;

    fpa_pkg::t_side    r_side [fpa_pkg::DIV_STAGES];
    fpa_pkg::t_side    tail;

    logic               r_valid, r_lt, r_eq, r_gt, r_ovf, r_dz;
    logic signed [31:0] r_res;
    logic               n_ovf;
    logic signed [31:0] n_res;
    logic [63:0]        mul_q, div_q;

    assign busy = 1'b0;

    fpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_op    (i_op),
        .i_a     (i_operand_a),
        .i_b     (i_operand_b),
        .o_side  (front_side),
        .o_mul   (mul_in),
        .o_div   (div_in)
    );

    fpa_mul u_mul (
        .i_clk  (i_clk),
        .i_mul  (mul_in),
        .o_prod (prod)
    );

    fpa_div u_div (
        .i_clk (i_clk),
        .i_div (div_in),
        .o_div (div_out)
    );

    function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic [32:0] rv;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                rv = {1'b1, fpa_pkg::S32_MIN};
            end else begin
                rv = {1'b0, 32'(-mag)};
            end
        end else begin
            if (mag > 64'(fpa_pkg::S32_MAX)) begin
                rv = {1'b1, fpa_pkg::S32_MAX};
            end else begin
                rv = {1'b0, mag[31:0]};
            end
        end
        return rv;
    endfunction

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < fpa_pkg::DIV_STAGES; k++) begin
            if (!i_rst_n) begin
                r_side[k].valid <= 1'b0;
            end else begin
                r_side[k].valid <= (k == 0) ? front_side.valid
                                            : r_side[(k == 0) ? 0 : k-1].valid;
            end
            if (k == 0) begin
                r_side[k].op  <= front_side.op;
                r_side[k].res <= front_side.res;
                r_side[k].ovf <= front_side.ovf;
                r_side[k].dz  <= front_side.dz;
                r_side[k].neg <= front_side.neg;
                r_side[k].lt  <= front_side.lt;
                r_side[k].eq  <= front_side.eq;
                r_side[k].gt  <= front_side.gt;
            end else begin
                r_side[k].op  <= r_side[k-1].op;
                r_side[k].res <= r_side[k-1].res;
                r_side[k].ovf <= r_side[k-1].ovf;
                r_side[k].dz  <= r_side[k-1].dz;
                r_side[k].neg <= r_side[k-1].neg;
                r_side[k].lt  <= r_side[k-1].lt;
                r_side[k].eq  <= r_side[k-1].eq;
                r_side[k].gt  <= r_side[k-1].gt;
            end
        end
    end

    assign tail = r_side[fpa_pkg::DIV_STAGES-1];

    always_comb begin
        mul_q = (prod + (64'(1) << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
        div_q = div_out.hi ? '1 : 64'(div_out.quo);
        n_ovf = tail.ovf;
        n_res = tail.res;
        case (tail.op)
            fpa_pkg::OP_MUL: {n_ovf, n_res} = sat_mag(tail.neg, mul_q);
            fpa_pkg::OP_DIV: begin
                if (!tail.dz) begin
                    {n_ovf, n_res} = sat_mag(tail.neg, div_q);
                end
            end
            default: begin
                n_ovf = tail.ovf;
                n_res = tail.res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= tail.valid;
        end
        r_res <= n_res;
        r_ovf <= n_ovf;
        r_dz  <= tail.dz;
        r_lt  <= tail.lt;
        r_eq  <= tail.eq;
        r_gt  <= tail.gt;
    end

    assign o_valid           = r_valid;
    assign o_result_value    = r_res;
    assign o_less_than       = r_lt;
    assign o_equal           = r_eq;
    assign o_greater_than    = r_gt;
    assign o_overflowed      = r_ovf;
    assign o_divided_by_zero = r_dz;

    `FPA_ASSERT_DELAY(a_latency, i_clk, i_rst_n, start && !busy, 35, o_valid, "word lost in pipeline")
    `FPA_ASSERT_SAME(a_cmp_onehot, i_clk, i_rst_n, o_valid, $countones({o_less_than, o_equal, o_greater_than}) == 1, "compare flags not one-hot")
    `FPA_ASSERT_SAME(a_dz_no_ovf, i_clk, i_rst_n, o_valid && o_divided_by_zero, !o_overflowed, "overflow with divide by zero")
    `FPA_ASSERT_SAME(a_ovf_sat, i_clk, i_rst_n, o_valid && o_overflowed, o_result_value == fpa_pkg::S32_MAX || o_result_value == fpa_pkg::S32_MIN, "overflow without saturated result")

endmodule
`default_nettype wire

/* sim/tb_fixed_point_alu.sv */
// Testbench for the fixed-point ALU: directed table plus random words, checked by a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_fixed_point_alu;

    typedef struct {
        logic [3:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               known;
        logic signed [31:0] res;
        logic               ovf;
        logic               dz;
    } t_row;

    typedef struct {
        logic signed [31:0] res;
        logic               lt;
        logic               eq;
        logic               gt;
        logic               ovf;
        logic               dz;
    } t_alu_out;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_RANDOM    = 1650;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [3:0]         i_op = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               busy;
    logic               o_valid;
    logic signed [31:0] o_result_value;
    logic               o_less_than;
    logic               o_equal;
    logic               o_greater_than;
    logic               o_overflowed;
    logic               o_divided_by_zero;

    t_alu_out pending_results[$];
    int       n_errors = 0;
    int       cycles = 0;

    fixed_point_alu uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] sat_sign_mag(input logic neg, input logic [63:0] mag,
                                                       ref logic ovf);
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                ovf = 1'b1;
                return fpa_pkg::S32_MIN;
            end
            return 32'(-$signed(mag[32:0]));
        end
        if (mag > 64'h7FFF_FFFF) begin
            ovf = 1'b1;
            return fpa_pkg::S32_MAX;
        end
        return mag[31:0];
    endfunction

    function automatic logic signed [31:0] clamp(input logic signed [63:0] v, ref logic ovf);
        if (v > 64'sh7FFF_FFFF) begin
            ovf = 1'b1;
            return fpa_pkg::S32_MAX;
        end
        if (v < -64'sh8000_0000) begin
            ovf = 1'b1;
            return fpa_pkg::S32_MIN;
        end
        return v[31:0];
    endfunction

    function automatic t_alu_out alu_predict(input logic [3:0] op, input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        t_alu_out          r;
        logic signed [63:0] sa, sb;
        logic [63:0]       ma, mb, p, n;
        logic              neg, ovf;
        sa = 64'(a);
        sb = 64'(b);
        ma = sa < 0 ? -sa : sa;
        mb = sb < 0 ? -sb : sb;
        neg = (sa < 0) != (sb < 0);
        ovf = 1'b0;
        r.dz = 1'b0;
        r.res = '0;
        case (op)
            fpa_pkg::OP_ADD: r.res = clamp(sa + sb, ovf);
            fpa_pkg::OP_SUB: r.res = clamp(sa - sb, ovf);
            fpa_pkg::OP_MUL: begin
                p = ma * mb;
                r.res = sat_sign_mag(neg, (p + (64'd1 << (fpa_pkg::FRAC_BITS - 1)))
                                          >> fpa_pkg::FRAC_BITS, ovf);
            end
            fpa_pkg::OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                    r.res = a > 0 ? fpa_pkg::S32_MAX : (a < 0 ? fpa_pkg::S32_MIN : 32'sd0);
                end else begin
                    n = ma << fpa_pkg::FRAC_BITS;
                    r.res = sat_sign_mag(neg, (2 * n + mb) / (2 * mb), ovf);
                end
            end
            fpa_pkg::OP_MIN:      r.res = a < b ? a : b;
            fpa_pkg::OP_MAX:      r.res = a > b ? a : b;
            fpa_pkg::OP_INC:      r.res = clamp(sa + 1, ovf);
            fpa_pkg::OP_DEC:      r.res = clamp(sa - 1, ovf);
            fpa_pkg::OP_TO_INT:   r.res = a >>> fpa_pkg::FRAC_BITS;
            fpa_pkg::OP_FROM_INT: r.res = clamp(sa * (64'sd1 <<< fpa_pkg::FRAC_BITS), ovf);
            default:              r.res = '0;
        endcase
        r.ovf = ovf;
        r.lt = a < b;
        r.eq = a == b;
        r.gt = a > b;
        return r;
    endfunction

    task automatic issue_word(input logic [3:0] op, input logic signed [31:0] a,
                              input logic signed [31:0] b);
        start <= 1'b1;
        i_op <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(alu_predict(op, a, b));
    endtask

    task automatic send_gap();
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_alu_out x;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result word with none expected");
                n_errors++;
            end else begin
                x = pending_results.pop_front();
                if (o_result_value !== x.res) begin
                    $error("result_value exp %0d got %0d", x.res, o_result_value);
                    n_errors++;
                end
                if (o_less_than !== x.lt) begin
                    $error("less_than exp %0b got %0b", x.lt, o_less_than);
                    n_errors++;
                end
                if (o_equal !== x.eq) begin
                    $error("equal exp %0b got %0b", x.eq, o_equal);
                    n_errors++;
                end
                if (o_greater_than !== x.gt) begin
                    $error("greater_than exp %0b got %0b", x.gt, o_greater_than);
                    n_errors++;
                end
                if (o_overflowed !== x.ovf) begin
                    $error("overflowed exp %0b got %0b", x.ovf, o_overflowed);
                    n_errors++;
                end
                if (o_divided_by_zero !== x.dz) begin
                    $error("divided_by_zero exp %0b got %0b", x.dz, o_divided_by_zero);
                    n_errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? fpa_pkg::S32_MAX - $urandom_range(0, 3)
                                           : fpa_pkg::S32_MIN + $urandom_range(0, 3);
            1: return $signed($urandom_range(0, 4095)) - 2048;
            2: return $signed($urandom) >>> $urandom_range(0, 31);
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    t_row dir_rows[] = '{
        '{fpa_pkg::OP_ADD, fpa_pkg::S32_MAX, 32'sd1, 1'b1, fpa_pkg::S32_MAX, 1'b1, 1'b0},
        '{fpa_pkg::OP_ADD, fpa_pkg::S32_MIN, -32'sd1, 1'b1, fpa_pkg::S32_MIN, 1'b1, 1'b0},
        '{fpa_pkg::OP_SUB, fpa_pkg::S32_MIN, 32'sd1, 1'b1, fpa_pkg::S32_MIN, 1'b1, 1'b0},
        '{fpa_pkg::OP_SUB, fpa_pkg::S32_MAX, -32'sd1, 1'b1, fpa_pkg::S32_MAX, 1'b1, 1'b0},
        '{fpa_pkg::OP_MUL, fpa_pkg::S32_MAX, fpa_pkg::S32_MAX, 1'b1, fpa_pkg::S32_MAX,
          1'b1, 1'b0},
        '{fpa_pkg::OP_MUL, fpa_pkg::S32_MIN, fpa_pkg::S32_MAX, 1'b1, fpa_pkg::S32_MIN,
          1'b1, 1'b0},
        '{fpa_pkg::OP_MUL, 32'sd384, 32'sd384, 1'b0, 0, 0, 0},
        '{fpa_pkg::OP_MUL, -32'sd1, 32'sd128, 1'b0, 0, 0, 0},
        '{fpa_pkg::OP_MUL, 32'sd1, 32'sd128, 1'b0, 0, 0, 0},
        '{fpa_pkg::OP_DIV, 32'sd5, 32'sd0, 1'b1, fpa_pkg::S32_MAX, 1'b0, 1'b1},
        '{fpa_pkg::OP_DIV, -32'sd5, 32'sd0, 1'b1, fpa_pkg::S32_MIN, 1'b0, 1'b1},
        '{fpa_pkg::OP_DIV, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b0, 1'b1},
        '{fpa_pkg::OP_DIV, fpa_pkg::S32_MIN, -32'sd1, 1'b1, fpa_pkg::S32_MAX, 1'b1, 1'b0},
        '{fpa_pkg::OP_DIV, -32'sd1, 32'sd512, 1'b0, 0, 0, 0},
        '{fpa_pkg::OP_DIV, fpa_pkg::S32_MIN, fpa_pkg::S32_MAX, 1'b0, 0, 0, 0},
        '{fpa_pkg::OP_MIN, fpa_pkg::S32_MIN, fpa_pkg::S32_MAX, 1'b1, fpa_pkg::S32_MIN,
          1'b0, 1'b0},
        '{fpa_pkg::OP_MAX, fpa_pkg::S32_MIN, fpa_pkg::S32_MAX, 1'b1, fpa_pkg::S32_MAX,
          1'b0, 1'b0},
        '{fpa_pkg::OP_CMP, 32'sd7, 32'sd7, 1'b1, 32'sd0, 1'b0, 1'b0},
        '{fpa_pkg::OP_INC, fpa_pkg::S32_MAX, 32'sd0, 1'b1, fpa_pkg::S32_MAX, 1'b1, 1'b0},
        '{fpa_pkg::OP_DEC, fpa_pkg::S32_MIN, 32'sd0, 1'b1, fpa_pkg::S32_MIN, 1'b1, 1'b0},
        '{fpa_pkg::OP_TO_INT, -32'sd1, 32'sd3, 1'b1, -32'sd1, 1'b0, 1'b0},
        '{fpa_pkg::OP_TO_INT, fpa_pkg::S32_MAX, 32'sd0, 1'b1, 32'sh007F_FFFF, 1'b0, 1'b0},
        '{fpa_pkg::OP_FROM_INT, 32'sh0080_0000, 32'sd0, 1'b1, fpa_pkg::S32_MAX, 1'b1, 1'b0},
        '{fpa_pkg::OP_FROM_INT, -32'sh0080_0001, 32'sd0, 1'b1, fpa_pkg::S32_MIN, 1'b1, 1'b0},
        '{4'd15, -32'sd3, 32'sd9, 1'b1, 32'sd0, 1'b0, 1'b0}
    };

    initial begin
        t_alu_out exp;
        int       wait_cycles;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k]) begin
            if (dir_rows[k].known) begin
                exp = alu_predict(dir_rows[k].op, dir_rows[k].a, dir_rows[k].b);
                if (exp.res !== dir_rows[k].res || exp.ovf !== dir_rows[k].ovf
                        || exp.dz !== dir_rows[k].dz) begin
                    $error("table row %0d disagrees with predictor", k);
                    n_errors++;
                end
            end
            issue_word(dir_rows[k].op, dir_rows[k].a, dir_rows[k].b);
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            send_gap();
            if (k == N_RANDOM / 2) begin
                start <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            issue_word($urandom_range(0, 15) == 0 ? 4'($urandom_range(11, 15))
                                                 : 4'($urandom_range(0, 10)),
                       rand_operand(), rand_operand());
        end
        start <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 1000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (fpa_pkg::LAT_CYCLES + 5) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
